// File: design/bcth_pkg.sv
// shared types and constants for the byte class transition histogram
// no dependencies

package bcth_pkg;

    localparam int BYTE_WIDTH   = 8;
    localparam int GROUP_WIDTH  = 3;
    localparam int OUT_WIDTH    = 32;
    localparam int TABLE_DEPTH  = 256;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_BYTE = 2'd1,
        OP_READ = 2'd2
    } op_t;

endpackage

// File: design/byte_class_transition_histogram.sv
// byte class transition histogram, top level
// depends on bcth_pkg

// Takes one request per clock while in_ready is high: class table loads, stream bytes and
// bin reads share the input channel, and every request gives exactly one result through
// the stage 1, stage 2 and output registers. The counter read-modify-write is split
// over two pipeline stages with forwarding from the write stage, so back-to-back bytes
// that hit the same bin still count correctly. Results wait in an output register while
// new requests keep flowing until the pipeline is full. After reset the block runs a
// clearing pass over the class table and the counters, with in_ready low; after that
// in_ready is low only while the output stalls.
// The class table must be loaded by software, including the group for bytes not named.

module byte_class_transition_histogram #(
    parameter int MAX_GROUPS  = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic [bcth_pkg::BYTE_WIDTH-1:0]    byte_value,
    input  logic [bcth_pkg::GROUP_WIDTH-1:0]   group_index,
    input  logic [bcth_pkg::GROUP_WIDTH-1:0]   from_group,
    input  logic [bcth_pkg::GROUP_WIDTH-1:0]   to_group,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bcth_pkg::OUT_WIDTH-1:0]     bin_count,
    output logic                               read_valid
);

    localparam int GW      = $clog2(MAX_GROUPS);
    localparam int BINS    = MAX_GROUPS * MAX_GROUPS;
    localparam int BW      = $clog2(BINS);
    localparam int CLR_LEN = (BINS > bcth_pkg::TABLE_DEPTH) ? BINS : bcth_pkg::TABLE_DEPTH;
    localparam int CLW     = $clog2(CLR_LEN);

    // memories
    logic [GW-1:0]          class_table [bcth_pkg::TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] count_mem   [BINS];

    // clearing pass
    logic           clearing_reg;
    logic [CLW-1:0] clr_reg;

    // stream position
    logic [bcth_pkg::BYTE_WIDTH-1:0] prev_byte_reg;
    logic                            seen_first_reg;

    // stage 1
    logic                           s1_valid_reg;
    logic [1:0]                     s1_op_reg;
    logic                           s1_count_reg;
    logic [GW-1:0]                  s1_gfrom_reg;
    logic [GW-1:0]                  s1_gto_reg;
    logic [bcth_pkg::GROUP_WIDTH-1:0] s1_rfrom_reg;
    logic [bcth_pkg::GROUP_WIDTH-1:0] s1_rto_reg;
    logic [BW-1:0]                  s1_idx;
    logic                           s1_in_range;

    // stage 2
    logic                   s2_valid_reg;
    logic [1:0]             s2_op_reg;
    logic                   s2_count_reg;
    logic                   s2_in_range_reg;
    logic [BW-1:0]          s2_idx_reg;
    logic [COUNT_WIDTH-1:0] s2_data_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic [bcth_pkg::OUT_WIDTH-1:0] sat_count;

    // output
    logic                           out_valid_reg;
    logic [bcth_pkg::OUT_WIDTH-1:0] bin_count_reg;
    logic                           read_valid_reg;

    logic out_adv;
    logic s2_adv;
    logic s1_adv;
    logic in_accept;
    logic cnt_wr;
    logic [GW-1:0] load_group;

    assign out_adv   = !out_valid_reg || out_ready;
    assign s2_adv    = !s2_valid_reg || out_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign in_ready  = s1_adv && !clearing_reg;
    assign in_accept = in_valid && in_ready;
    assign cnt_wr    = s2_valid_reg && out_adv && s2_count_reg;

    assign out_valid  = out_valid_reg;
    assign bin_count  = bin_count_reg;
    assign read_valid = read_valid_reg;

    // group saturated to the last one
    always_comb
    begin
        if (int'(group_index) >= MAX_GROUPS)
        begin
            load_group = GW'(MAX_GROUPS - 1);
        end
        else
        begin
            load_group = GW'(group_index);
        end
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_reg      <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_reg == CLW'(CLR_LEN - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // class table write port and two read ports
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (int'(clr_reg) < bcth_pkg::TABLE_DEPTH)
            begin
                class_table[clr_reg[bcth_pkg::BYTE_WIDTH-1:0]] <= '0;
            end
        end
        else if (in_accept && op == bcth_pkg::OP_LOAD)
        begin
            class_table[byte_value] <= load_group;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_gfrom_reg <= class_table[prev_byte_reg];
            s1_gto_reg   <= class_table[byte_value];
            s1_op_reg    <= op;
            s1_count_reg <= (op == bcth_pkg::OP_BYTE) && seen_first_reg;
            s1_rfrom_reg <= from_group;
            s1_rto_reg   <= to_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= '0;
            seen_first_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept && op == bcth_pkg::OP_BYTE)
            begin
                prev_byte_reg  <= byte_value;
                seen_first_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // bin index
    always_comb
    begin
        s1_in_range = (int'(s1_rfrom_reg) < MAX_GROUPS) && (int'(s1_rto_reg) < MAX_GROUPS);
        if (s1_op_reg == bcth_pkg::OP_READ)
        begin
            s1_idx = BW'(int'(s1_rfrom_reg) * MAX_GROUPS + int'(s1_rto_reg));
        end
        else
        begin
            s1_idx = BW'(int'(s1_gfrom_reg) * MAX_GROUPS + int'(s1_gto_reg));
        end
    end

    // saturating increment
    assign cnt_next = (&s2_data_reg) ? s2_data_reg : s2_data_reg + 1'b1;

    // counter memory, read with forwarding from the write stage
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            if (int'(clr_reg) < BINS)
            begin
                count_mem[clr_reg[BW-1:0]] <= '0;
            end
        end
        else if (cnt_wr)
        begin
            count_mem[s2_idx_reg] <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            if (cnt_wr && s2_idx_reg == s1_idx)
            begin
                s2_data_reg <= cnt_next;
            end
            else
            begin
                s2_data_reg <= count_mem[s1_idx];
            end
            s2_op_reg       <= s1_op_reg;
            s2_count_reg    <= s1_count_reg;
            s2_in_range_reg <= s1_in_range;
            s2_idx_reg      <= s1_idx;
        end
    end

    // fit the counter to the output width
    generate
        if (COUNT_WIDTH > bcth_pkg::OUT_WIDTH)
        begin : g_sat
            assign sat_count = (|s2_data_reg[COUNT_WIDTH-1:bcth_pkg::OUT_WIDTH]) ?
                               '1 : s2_data_reg[bcth_pkg::OUT_WIDTH-1:0];
        end
        else
        begin : g_ext
            assign sat_count = bcth_pkg::OUT_WIDTH'(s2_data_reg);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (out_adv && s2_valid_reg)
        begin
            if (s2_op_reg == bcth_pkg::OP_READ)
            begin
                read_valid_reg <= 1'b1;
                bin_count_reg  <= s2_in_range_reg ? sat_count : '0;
            end
            else
            begin
                read_valid_reg <= 1'b0;
                bin_count_reg  <= '0;
            end
        end
    end

endmodule

// File: design/bcth_checker.sv
// port-level checks for the byte class transition histogram, with its bind
// depends on bcth_pkg and byte_class_transition_histogram

module bcth_checker #(
    parameter int MAX_GROUPS = 8
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [1:0]                       op,
    input logic [bcth_pkg::GROUP_WIDTH-1:0] from_group,
    input logic [bcth_pkg::GROUP_WIDTH-1:0] to_group,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [bcth_pkg::OUT_WIDTH-1:0]   bin_count,
    input logic                             read_valid
);

    logic read_req;
    logic other_req;
    logic bad_read;

    assign read_req  = in_valid && in_ready && op == bcth_pkg::OP_READ;
    assign other_req = in_valid && in_ready && op != bcth_pkg::OP_READ;
    assign bad_read  = read_req &&
                       (int'(from_group) >= MAX_GROUPS || int'(to_group) >= MAX_GROUPS);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bin_count) && $stable(read_valid))
        else $error("stalled result changed");

    // results that are not reads carry zero
    a_zero_nonread: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> bin_count == '0)
        else $error("non-read result with nonzero count");

    // a read request shows up as read data when the output side does not stall
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        read_req ##1 out_ready ##1 out_ready |=> out_valid && read_valid)
        else $error("read result missing");

    // loads and bytes give no read data
    a_other_latency: assert property (@(posedge clk) disable iff (!rst_n)
        other_req ##1 out_ready ##1 out_ready |=> out_valid && !read_valid)
        else $error("non-read request produced read data");

    // out of range bins read as zero
    a_bad_read: assert property (@(posedge clk) disable iff (!rst_n)
        bad_read ##1 out_ready ##1 out_ready |=> out_valid && read_valid && bin_count == '0)
        else $error("out of range bin not zero");

endmodule

bind byte_class_transition_histogram bcth_checker #(.MAX_GROUPS(MAX_GROUPS)) u_bcth_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .from_group  (from_group),
    .to_group    (to_group),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .bin_count   (bin_count),
    .read_valid  (read_valid)
);
